// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box mean filter
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define BM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("box mean: property violated");

// Condition must never be true at a clock edge outside reset
`define BM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("box mean: forbidden condition seen");

`endif

// ===== sv/bmean_pkg.sv =====
// ----------------------------------------------------------------------------
// bmean_pkg
// Shared types and constants of the 3x3 edge-aware box mean filter.
// ----------------------------------------------------------------------------
package bmean_pkg;

  // Default geometry limits
  localparam int BM_MAX_WIDTH  = 1024;
  localparam int BM_MAX_HEIGHT = 4096;

  // Pixel and window geometry
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int PIX_W     = CHAN_W * NUM_CHAN;
  localparam int WIN_SIDE  = 3;
  localparam int WIN_TAPS  = WIN_SIDE * WIN_SIDE;
  // Nine bytes summed: 9 * 255 fits in 12 bits
  localparam int SUM_W     = 12;

  // Configuration register file
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int IMG_W_BITS  = 11;
  localparam int IMG_H_BITS  = 13;
  localparam int IMG_W_RESET = 640;
  localparam int IMG_H_RESET = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // Request payloads
  typedef struct packed {
    logic [CHAN_W-1:0] chan_zero;
    logic [CHAN_W-1:0] chan_one;
    logic [CHAN_W-1:0] chan_two;
    logic              drain;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] mean_zero;
    logic [CHAN_W-1:0] mean_one;
    logic [CHAN_W-1:0] mean_two;
    logic              frame_end;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take;    // capture pixel, read line buffers
    logic update;  // shift window, write line buffers, advance input position
    logic sum;     // register neighbourhood sums, advance output position
    logic load;    // divide and load the output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic flushing;  // all pixels of the frame are in
    logic emit;      // current tick produces a result
    logic out_busy;  // output register holds a result not yet taken
  } ctrl_sts_t;

endpackage

// ===== sv/box_mean_3x3_edge_aware_top.sv =====
// ----------------------------------------------------------------------------
// box_mean_3x3_edge_aware_top
// 3x3 box mean over a raster stream of three-channel pixels; border pixels
// average only the neighbours inside the image (divide by 1, 2, 3, 4, 6 or 9).
// Requests come in on in_valid/in_ready with in_data; results leave on
// out_valid/out_ready with out_data; cfg_we/cfg_index/cfg_wdata set width
// and height and restart the frame position. Write config only when idle.
// The result for a pixel leaves with the request that brings the pixel one
// line plus one further on; after the last pixel send drain requests to push
// out the trailing line. frame_end marks the frame's last result.
// out_valid is registered: it rises once the divide step loads a result.
// The sequencer steps each request through read, window update, sum and
// divide in turn; a request with no result returns to idle after the window
// update, and a drain dropped inside a frame leaves the sequencer idle.
// The output register lets the next request in while a result waits; if the
// receiver stalls, the following result holds in the divide step.
// Reset: geometry 640x480, positions and window cleared, no output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_mean_3x3_edge_aware_top
  import bmean_pkg::*;
#(
  parameter int MAX_WIDTH  = BM_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencer
  bmean_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_drain (in_data.drain),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  bmean_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Never overwrite a result the receiver has not taken
  `BM_ASSERT_NEVER(a_load_over_held, cmd.load && out_valid && !out_ready)
  // A taken request closes the input until its work is done
  `BM_ASSERT(a_take_drops_ready, cmd.take |=> !in_ready)
  // A result only appears after the divide step loaded it
  `BM_ASSERT(a_result_from_load, $rose(out_valid) |-> $past(cmd.load))

endmodule

// ===== sv/bmean_linebuf.sv =====
// ----------------------------------------------------------------------------
// bmean_linebuf
// Two line buffers packed side by side in one memory: one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module bmean_linebuf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/bmean_ctrl.sv =====
// ----------------------------------------------------------------------------
// bmean_ctrl
// Sequencer of the box mean filter: accepts one request, steps it through window
// update and, for a result, summation and division, then waits for the output register.
// ----------------------------------------------------------------------------
module bmean_ctrl
  import bmean_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_drain,
  output logic      in_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SUM,
    ST_DIV
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   accept;

  // Decode commands and next state
  always_comb begin
    accept     = in_valid && in_ready_r;
    // drop a drain request while pixels of the frame are still due
    cmd.take   = accept && !(in_drain && !sts.flushing);
    cmd.update = (state_r == ST_UPDATE);
    cmd.sum    = (state_r == ST_SUM);
    cmd.load   = (state_r == ST_DIV) && !sts.out_busy;

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.take) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = sts.emit ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    in_ready_nxt = (state_nxt == ST_IDLE);
  end

  // Hold state and ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ===== sv/bmean_dp.sv =====
// ----------------------------------------------------------------------------
// bmean_dp
// Datapath of the box mean filter: geometry registers, raster positions,
// line buffers, 3x3 window, edge-aware sums, constant dividers and the
// output register.
// ----------------------------------------------------------------------------
module bmean_dp
  import bmean_pkg::*;
#(
  parameter int MAX_WIDTH  = BM_MAX_WIDTH,
  parameter int MAX_HEIGHT = BM_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_sts_t             sts,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_item_t             out_data
);

  localparam int CW = $clog2(MAX_WIDTH);        // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);    // effective width
  localparam int HW = $clog2(MAX_HEIGHT + 1);   // effective height, output row
  localparam int RW = $clog2(MAX_HEIGHT + 3);   // input row runs past the frame
  localparam int PW = 2 * SUM_W + 4;            // reciprocal product width

  localparam logic [PW-1:0] DIV3_MUL   = PW'(2731);
  localparam int            DIV3_SHIFT = 13;
  localparam logic [PW-1:0] DIV9_MUL   = PW'(3641);
  localparam int            DIV9_SHIFT = 15;

  typedef enum logic [2:0] {
    DIV_1,
    DIV_2,
    DIV_3,
    DIV_4,
    DIV_6,
    DIV_9
  } div_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] hi);
    logic [31:0] res;
    res = v;
    if (v == 32'd0) begin
      res = 32'd1;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  // Exact for sums below 2^13
  function automatic logic [SUM_W-1:0] div3(logic [SUM_W-1:0] s);
    logic [PW-1:0] p;
    p = PW'(s) * DIV3_MUL;
    return p[DIV3_SHIFT +: SUM_W];
  endfunction

  // Exact for sums below 2^15
  function automatic logic [SUM_W-1:0] div9(logic [SUM_W-1:0] s);
    logic [PW-1:0] p;
    p = PW'(s) * DIV9_MUL;
    return p[DIV9_SHIFT +: SUM_W];
  endfunction

  localparam logic [WW-1:0] W_RESET = WW'(clamp_dim(32'(IMG_W_RESET), 32'(MAX_WIDTH)));
  localparam logic [HW-1:0] H_RESET = HW'(clamp_dim(32'(IMG_H_RESET), 32'(MAX_HEIGHT)));

  logic [WW-1:0]     w_eff_r;
  logic [HW-1:0]     h_eff_r;
  logic [CW-1:0]     in_col_r, in_col_nxt;
  logic [RW-1:0]     in_row_r, in_row_nxt;
  logic [CW-1:0]     out_col_r, out_col_nxt;
  logic [HW-1:0]     out_row_r, out_row_nxt;
  logic [PIX_W-1:0]  pix_r;
  logic [PIX_W-1:0]  win_r [WIN_TAPS];
  logic [SUM_W-1:0]  sum_r [NUM_CHAN];
  logic [SUM_W-1:0]  sum_nxt [NUM_CHAN];
  div_t              div_r, div_nxt;
  logic              last_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [2*PIX_W-1:0] lb_rd_data;
  logic [PIX_W-1:0]   lb_upper, lb_middle;
  logic [WW-1:0]      in_col_inc, out_col_inc;
  logic               edge_top, edge_bottom, edge_left, edge_right, last_c;
  logic [1:0]         n_rows, n_cols;
  logic [3:0]         n_taps;
  logic [WIN_SIDE-1:0] row_ok, col_ok;
  logic [WIN_TAPS-1:0] tap_ok;
  logic [SUM_W-1:0]   acc;
  logic [SUM_W-1:0]   quo [NUM_CHAN];

  // Geometry registers, stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= W_RESET;
      h_eff_r <= H_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          w_eff_r <= WW'(clamp_dim(32'(cfg_wdata[IMG_W_BITS-1:0]), 32'(MAX_WIDTH)));
        end
        CFG_IMAGE_HEIGHT: begin
          h_eff_r <= HW'(clamp_dim(32'(cfg_wdata[IMG_H_BITS-1:0]), 32'(MAX_HEIGHT)));
        end
        default: begin
        end
      endcase
    end
  end

  // Status towards the controller
  always_comb begin
    sts.flushing = (32'(in_row_r) >= 32'(h_eff_r));
    sts.emit     = (in_row_r > RW'(1)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
    sts.out_busy = out_valid_r && !out_ready;
  end

  // Capture the pixel; a tick during the flush carries zero
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_r <= sts.flushing ? '0
             : {in_data.chan_two, in_data.chan_one, in_data.chan_zero};
    end
  end

  // Line buffers: upper row in the high half, middle row in the low half
  bmean_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (2 * PIX_W)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (cmd.take),
    .rd_addr (in_col_r),
    .rd_data (lb_rd_data),
    .wr_en   (cmd.update),
    .wr_addr (in_col_r),
    .wr_data ({lb_middle, pix_r})
  );

  assign lb_upper  = lb_rd_data[2*PIX_W-1:PIX_W];
  assign lb_middle = lb_rd_data[PIX_W-1:0];

  // Shift the window one column and bring in the new right column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int r = 0; r < WIN_SIDE; r++) begin
        for (int c = 0; c < WIN_SIDE - 1; c++) begin
          win_r[r*WIN_SIDE + c] <= win_r[r*WIN_SIDE + c + 1];
        end
      end
      win_r[WIN_SIDE - 1]            <= lb_upper;
      win_r[2*WIN_SIDE - 1]          <= lb_middle;
      win_r[WIN_SIDE*WIN_SIDE - 1]   <= pix_r;
    end
  end

  // Border tests for the output position
  always_comb begin
    in_col_inc  = WW'(in_col_r) + WW'(1);
    out_col_inc = WW'(out_col_r) + WW'(1);
    edge_top    = (out_row_r != '0);
    edge_bottom = ((out_row_r + HW'(1)) < h_eff_r);
    edge_left   = (out_col_r != '0);
    edge_right  = (out_col_inc < w_eff_r);
    last_c      = !edge_bottom && !edge_right;
    n_rows      = 2'd1 + {1'b0, edge_top} + {1'b0, edge_bottom};
    n_cols      = 2'd1 + {1'b0, edge_left} + {1'b0, edge_right};
    n_taps      = {2'b00, n_rows} * {2'b00, n_cols};
  end

  // Raster positions of the next request and the next result
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_we) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (cmd.update) begin
      if (in_col_inc >= w_eff_r) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + RW'(1);
      end else begin
        in_col_nxt = CW'(in_col_inc);
      end
    end else if (cmd.sum) begin
      if (last_c) begin
        // frame done: restart all positions
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else if (out_col_inc >= w_eff_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + HW'(1);
      end else begin
        out_col_nxt = CW'(out_col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // Sum the taps that lie inside the image, per channel
  always_comb begin
    row_ok = {edge_bottom, 1'b1, edge_top};
    col_ok = {edge_right, 1'b1, edge_left};
    for (int r = 0; r < WIN_SIDE; r++) begin
      for (int c = 0; c < WIN_SIDE; c++) begin
        tap_ok[r*WIN_SIDE + c] = row_ok[r] && col_ok[c];
      end
    end
    acc = '0;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc = '0;
      for (int k = 0; k < WIN_TAPS; k++) begin
        if (tap_ok[k]) begin
          acc = acc + SUM_W'(win_r[k][ch*CHAN_W +: CHAN_W]);
        end
      end
      sum_nxt[ch] = acc;
    end
    case (n_taps)
      4'd1:    div_nxt = DIV_1;
      4'd2:    div_nxt = DIV_2;
      4'd3:    div_nxt = DIV_3;
      4'd4:    div_nxt = DIV_4;
      4'd6:    div_nxt = DIV_6;
      default: div_nxt = DIV_9;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        sum_r[ch] <= sum_nxt[ch];
      end
      div_r  <= div_nxt;
      last_r <= last_c;
    end
  end

  // Divide by the tap count: shifts and reciprocal products
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      case (div_r)
        DIV_1:   quo[ch] = sum_r[ch];
        DIV_2:   quo[ch] = sum_r[ch] >> 1;
        DIV_3:   quo[ch] = div3(sum_r[ch]);
        DIV_4:   quo[ch] = sum_r[ch] >> 2;
        DIV_6:   quo[ch] = div3(sum_r[ch] >> 1);
        DIV_9:   quo[ch] = div9(sum_r[ch]);
        default: quo[ch] = sum_r[ch];
      endcase
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.mean_zero <= quo[0][CHAN_W-1:0];
      out_data_r.mean_one  <= quo[1][CHAN_W-1:0];
      out_data_r.mean_two  <= quo[2][CHAN_W-1:0];
      out_data_r.frame_end <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/box_mean_3x3_edge_aware_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_mean_3x3_edge_aware_top_test
// Self-checking bench for the 3x3 edge-aware box mean filter. A queue of
// pixel and drain requests feeds a bursty driver. A behavioural model of
// the line buffers, window and border divisors predicts each mean when a
// request is taken. A monitor behind a stalling sink compares every result
// with the oldest prediction. Geometry is changed only while the block is
// idle; small frames dominate, with a few extreme sizes in between.
// ----------------------------------------------------------------------------
module box_mean_3x3_edge_aware_top_test;
  import bmean_pkg::*;

  localparam int RANDOM_REQS   = 500;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int COL_W         = $clog2(BM_MAX_WIDTH);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  // Requests waiting to be driven and means waiting to be seen
  in_item_t  pending_px[$];
  out_item_t expected_means[$];
  int        fail_count = 0;
  int        random_reqs = 0;

  // Model state: geometry, line buffers, window and raster positions
  bit [IMG_W_BITS-1:0] geo_width = IMG_W_BITS'(IMG_W_RESET);
  bit [IMG_H_BITS-1:0] geo_height = IMG_H_BITS'(IMG_H_RESET);
  bit [PIX_W-1:0]      line_up2 [BM_MAX_WIDTH];
  bit [PIX_W-1:0]      line_up1 [BM_MAX_WIDTH];
  bit [PIX_W-1:0]      nbhd [WIN_TAPS];
  int unsigned         in_x, out_x;
  int unsigned         in_y, out_y;

  // Sender burst shaping and sink stall pattern
  int burst_left = 0;
  int gap_left = 0;
  int taken_count = 0;
  int hold_left = 0;
  int sink_mode = 0;
  int sink_cycle = 0;
  int quiet_cycles = 0;

  box_mean_3x3_edge_aware_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic clear_positions();
    in_x = 0;
    in_y = 0;
    out_x = 0;
    out_y = 0;
  endtask

  // Advance the model by one taken request; queue the mean it releases
  task automatic box_mean_step(input in_item_t req);
    int unsigned w, h, rows, cols, count, k, ch;
    int unsigned acc [NUM_CHAN];
    bit flushing, emit, top, bottom, left, right, last;
    bit [PIX_W-1:0] px;
    bit [COL_W-1:0] col;
    out_item_t res;
    w = (geo_width == 0) ? 1
      : (geo_width > BM_MAX_WIDTH) ? BM_MAX_WIDTH : 32'(geo_width);
    h = (geo_height == 0) ? 1
      : (geo_height > BM_MAX_HEIGHT) ? BM_MAX_HEIGHT : 32'(geo_height);
    flushing = in_y >= h;
    // drop drains while pixels of the frame are still due
    if (req.drain && !flushing) return;
    px = flushing ? '0 : {req.chan_two, req.chan_one, req.chan_zero};
    col = COL_W'(in_x);
    for (k = 0; k < WIN_SIDE; k++) begin
      nbhd[k*3]   = nbhd[k*3+1];
      nbhd[k*3+1] = nbhd[k*3+2];
    end
    nbhd[2] = line_up2[col];
    nbhd[5] = line_up1[col];
    nbhd[8] = px;
    line_up2[col] = line_up1[col];
    line_up1[col] = px;
    emit = (in_y > 1) || (in_y == 1 && in_x >= 1);
    in_x++;
    if (in_x >= w) begin
      in_x = 0;
      in_y++;
    end
    if (!emit) return;
    top    = out_y > 0;
    bottom = out_y + 1 < h;
    left   = out_x > 0;
    right  = out_x + 1 < w;
    rows   = 1 + (top ? 1 : 0) + (bottom ? 1 : 0);
    cols   = 1 + (left ? 1 : 0) + (right ? 1 : 0);
    count  = rows * cols;
    last   = (out_y + 1 >= h) && (out_x + 1 >= w);
    // sum only the taps that fall inside the image
    for (ch = 0; ch < NUM_CHAN; ch++) begin
      acc[ch] = 0;
      for (k = 0; k < WIN_TAPS; k++) begin
        if (k / 3 == 0 && !top) continue;
        if (k / 3 == 2 && !bottom) continue;
        if (k % 3 == 0 && !left) continue;
        if (k % 3 == 2 && !right) continue;
        acc[ch] += 32'(nbhd[k][8*ch +: 8]);
      end
    end
    res.mean_zero = 8'(acc[0] / count);
    res.mean_one  = 8'(acc[1] / count);
    res.mean_two  = 8'(acc[2] / count);
    res.frame_end = last;
    expected_means.push_back(res);
    if (last) begin
      clear_positions();
    end else begin
      out_x++;
      if (out_x >= w) begin
        out_x = 0;
        out_y++;
      end
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: pick_byte = 8'h00;
      1: pick_byte = 8'hFF;
      default: pick_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t make_req(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                        logic drain);
    make_req.chan_zero = c0;
    make_req.chan_one  = c1;
    make_req.chan_two  = c2;
    make_req.drain     = drain;
  endfunction

  function automatic in_item_t make_pixel();
    make_pixel = make_req(pick_byte(), pick_byte(), pick_byte(), 1'b0);
  endfunction

  function automatic in_item_t make_drain();
    make_drain = make_req(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'b1);
  endfunction

  task automatic queue_pixels(input int unsigned n);
    repeat (n) pending_px.push_back(make_pixel());
  endtask

  // One frame of w x h pixels and its flush; a broken frame stops early
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit intact);
    int unsigned ticks, k;
    ticks = intact ? w*h + w + 1 : $urandom_range(1, w*h + w);
    for (k = 0; k < ticks; k++) begin
      if (k < w*h) begin
        // stray drain inside the frame, dropped by the block
        if ($urandom_range(0, 15) == 0) pending_px.push_back(make_drain());
        pending_px.push_back(make_pixel());
      end else begin
        pending_px.push_back($urandom_range(0, 9) == 0 ? make_pixel() : make_drain());
      end
    end
    random_reqs += ticks;
    if (intact && $urandom_range(0, 4) == 0) pending_px.push_back(make_drain());
  endtask

  // Hold until all requests are in and all means are out, then let it settle
  task automatic wait_block_idle();
    while (pending_px.size() != 0 || in_valid || expected_means.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_IMAGE_WIDTH) geo_width = value[IMG_W_BITS-1:0];
    else geo_height = value;
    clear_positions();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w_val,
                              input logic [CFG_DATA_W-1:0] h_val);
    wait_block_idle();
    write_reg(CFG_IMAGE_WIDTH, w_val);
    write_reg(CFG_IMAGE_HEIGHT, h_val);
    @(negedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned w, h, frames, f;
    logic [CFG_DATA_W-1:0] w_val, h_val;
    bit intact;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame: corners, edges, centre, a stray drain, a pixel in the flush
    set_geometry(3, 3);
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'hFF, 8'h00, 8'h80, 1'b0));
    pending_px.push_back(make_req(8'h00, 8'h00, 8'h00, 1'b0));
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'h12, 8'h34, 8'h56, 1'b1));
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'h01, 8'hFE, 8'h7F, 1'b0));
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'h00, 8'hFF, 8'h01, 1'b0));
    pending_px.push_back(make_req(8'h00, 8'h00, 8'h00, 1'b1));
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b1));
    pending_px.push_back(make_req(8'hAA, 8'h55, 8'hAA, 1'b0));
    pending_px.push_back(make_req(8'h00, 8'h00, 8'h00, 1'b1));
    // single pixel image, then a two pixel row
    set_geometry(1, 1);
    pending_px.push_back(make_req(8'hFF, 8'h00, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'h00, 8'h00, 8'h00, 1'b1));
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b1));
    set_geometry(2, 1);
    pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b0));
    pending_px.push_back(make_req(8'h00, 8'h00, 8'h00, 1'b0));
    repeat (3) pending_px.push_back(make_req(8'hFF, 8'hFF, 8'hFF, 1'b1));

    // Extreme geometry: full width, oversize values, zero values
    set_geometry(1024, 13'h1FFF);
    queue_pixels(1024 + 6);
    set_geometry(13'h1FFF, 13'h0000);
    queue_pixels(30);
    set_geometry(0, 4096);
    queue_pixels(12);
    set_geometry(13'h1803, 2);
    queue_frame(3, 2, 1'b1);
    set_geometry(1, 0);
    queue_frame(1, 1, 1'b1);

    // Random frames, mostly complete, mostly small
    while (random_reqs < RANDOM_REQS) begin
      case ($urandom_range(0, 19))
        16, 17, 18: begin
          w = $urandom_range(9, 40);
          h = $urandom_range(1, 3);
        end
        19: begin
          w = $urandom_range(1, 3);
          h = $urandom_range(20, 40);
        end
        default: begin
          w = $urandom_range(1, 8);
          h = $urandom_range(1, 6);
        end
      endcase
      w_val = (w == 1 && $urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'(w);
      if ($urandom_range(0, 3) == 0) w_val[12:11] = 2'($urandom_range(1, 3));
      h_val = (h == 1 && $urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'(h);
      set_geometry(w_val, h_val);
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        intact = $urandom_range(0, 9) != 0;
        queue_frame(w, h, intact);
        if (!intact) break;
      end
    end

    wait_block_idle();
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk) begin : req_driver
    bit nxt_valid;
    in_item_t nxt_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_req   = in_data;
      if (in_valid && in_ready) begin
        box_mean_step(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_px.size() > 0) begin
          nxt_req   = pending_px.pop_front();
          nxt_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
            gap_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(0, 4);
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_req;
    end
  end

  // Result sink: switches between random stall patterns; two long hold-offs
  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        taken_count++;
        if (taken_count == 120 || taken_count == 260) hold_left = HOLD_CYCLES;
      end
      if (sink_cycle % 64 == 0) sink_mode = $urandom_range(0, 3);
      sink_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (sink_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result with the oldest predicted mean
  always @(posedge clk) begin : mean_monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        $display("%0t: result with none pending, expected nothing, got %h",
                 $time, out_data);
        fail_count++;
      end else begin
        want = expected_means.pop_front();
        compare_field("mean_zero", 32'(want.mean_zero), 32'(out_data.mean_zero));
        compare_field("mean_one", 32'(want.mean_one), 32'(out_data.mean_one));
        compare_field("mean_two", 32'(want.mean_two), 32'(out_data.mean_two));
        compare_field("frame_end", 32'(want.frame_end), 32'(out_data.frame_end));
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/bmean_pkg.sv
sv/bmean_linebuf.sv
sv/bmean_ctrl.sv
sv/bmean_dp.sv
sv/box_mean_3x3_edge_aware_top.sv
sim/box_mean_3x3_edge_aware_top_test.sv
